>>> rtl/core/zchs_pkg.sv
// Package for the zero-crossing half-bit sampler.
// Holds register codes, reset values and fixed widths; no dependencies.
package zchs_pkg;

    // Fixed widths of the configuration port and the crossing counter
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 4;
    localparam int CNT_BITS      = 4;
    localparam int FRAC_BITS     = 16;

    typedef logic [CNT_BITS-1:0] t_cnt;
    typedef logic [3:0]          t_shift;

    // Register indexes of the configuration port
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_ENABLE_FILTER = 3'd0,
        CFG_SIGNAL_SHIFT  = 3'd1,
        CFG_DC_SHIFT      = 3'd2,
        CFG_EARLY_OFFSET  = 3'd3,
        CFG_LATE_OFFSET   = 3'd4
    } t_cfg_reg;

    // Reset values of the registers
    localparam logic   RST_ENABLE_FILTER = 1'b1;
    localparam t_shift RST_SIGNAL_SHIFT  = 4'd2;
    localparam t_shift RST_DC_SHIFT      = 4'd7;
    localparam t_cnt   RST_EARLY_OFFSET  = 4'd2;
    localparam t_cnt   RST_LATE_OFFSET   = 4'd7;

    // Saturation value of the crossing counter
    localparam t_cnt CNT_MAX = 4'd15;

    // Sample point codes
    localparam logic POINT_EARLY = 1'b0;
    localparam logic POINT_LATE  = 1'b1;

endpackage

>>> rtl/core/zchs_in_if.sv
// Input channel of the zero-crossing half-bit sampler: one audio sample per item.
// Valid/ready handshake; no dependencies.
interface zchs_in_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

>>> rtl/core/zchs_out_if.sv
// Output channel of the zero-crossing half-bit sampler: one half-bit per item.
// Valid/ready handshake; no dependencies.
interface zchs_out_if;
    logic valid;
    logic ready;
    logic polarity;
    logic sample_point;

    modport source (output valid, output polarity, output sample_point, input ready);
    modport sink   (input valid, input polarity, input sample_point, output ready);
endinterface

>>> rtl/core/zero_crossing_halfbit_sampler_unit.sv
// Top level of the zero-crossing half-bit sampler.
// Depends on zchs_pkg, zchs_in_if and zchs_out_if.
//
// Takes one signed sample per cycle and gives a half-bit item at the early and
// late sample points after each zero crossing. An accepted sample updates the
// fast and slow Q16 low-pass filters at once while filtering is on, and enters
// stage one; stage one forms the band-limited sample (the raw sample while
// filtering is off), checks for a crossing and, as it advances, loads the output
// register when a half-bit is due; the result is offered from the output register.
// The sustained rate is one sample per cycle, set by the single filter update
// path, as long as the output side keeps up; while a result waits in the output
// register, stage one holds its item and, once it is full, the input stalls until the result is taken.

module zero_crossing_halfbit_sampler_unit #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [zchs_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  logic [zchs_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    zchs_in_if.sink                              i_in,
    zchs_out_if.source                           o_out
);

    localparam int AW = SAMPLE_BITS + zchs_pkg::FRAC_BITS;  // filter state width
    localparam int DW = AW + 1;                             // difference width

    // Configuration registers
    logic                 r_en;
    zchs_pkg::t_shift     r_sig_shift;
    zchs_pkg::t_shift     r_dc_shift;
    zchs_pkg::t_cnt       r_early;
    zchs_pkg::t_cnt       r_late;

    // Filter state and stage-one item
    logic signed [AW-1:0]          r_fast, r_slow;
    logic signed [SAMPLE_BITS-1:0] r_raw;
    logic                          r_s1_vld;

    // Crossing state
    logic                 r_prev_neg;
    zchs_pkg::t_cnt       r_cnt;

    // Output register
    logic                 r_out_vld;
    logic                 r_out_bit;
    logic                 r_out_pt;

    // Combinational signals
    logic                          in_acc, out_free, s1_adv;
    logic signed [AW-1:0]          x_q16;
    logic signed [DW-1:0]          d_fast, d_slow, sh_fast, sh_slow, d_avg;
    logic signed [AW-1:0]          n_fast, n_slow;
    logic signed [SAMPLE_BITS:0]   filt_wide;
    logic signed [SAMPLE_BITS-1:0] filt_sat, used;
    logic                          neg, pos, crossing, hit_e, hit_l, emit;
    zchs_pkg::t_cnt                n_cnt;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en        <= zchs_pkg::RST_ENABLE_FILTER;
            r_sig_shift <= zchs_pkg::RST_SIGNAL_SHIFT;
            r_dc_shift  <= zchs_pkg::RST_DC_SHIFT;
            r_early     <= zchs_pkg::RST_EARLY_OFFSET;
            r_late      <= zchs_pkg::RST_LATE_OFFSET;
        end else if (i_cfg_we) begin
            unique case (zchs_pkg::t_cfg_reg'(i_cfg_idx))
                zchs_pkg::CFG_ENABLE_FILTER: r_en        <= i_cfg_data[0];
                zchs_pkg::CFG_SIGNAL_SHIFT:  r_sig_shift <= i_cfg_data;
                zchs_pkg::CFG_DC_SHIFT:      r_dc_shift  <= i_cfg_data;
                zchs_pkg::CFG_EARLY_OFFSET:  r_early     <= i_cfg_data;
                zchs_pkg::CFG_LATE_OFFSET:   r_late      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Handshake: stage one advances only when the output register can take a result
    assign out_free    = !r_out_vld || o_out.ready;
    assign s1_adv      = r_s1_vld && out_free;
    assign i_in.ready  = !r_s1_vld || s1_adv;
    assign in_acc      = i_in.valid && i_in.ready;

    // Filter update: q += (x - q) >>> shift, flooring shift
    always_comb begin
        x_q16   = {i_in.sample, {zchs_pkg::FRAC_BITS{1'b0}}};
        d_fast  = {x_q16[AW-1], x_q16} - {r_fast[AW-1], r_fast};
        d_slow  = {x_q16[AW-1], x_q16} - {r_slow[AW-1], r_slow};
        sh_fast = d_fast >>> r_sig_shift;
        sh_slow = d_slow >>> r_dc_shift;
        n_fast  = r_fast + sh_fast[AW-1:0];
        n_slow  = r_slow + sh_slow[AW-1:0];
    end

    // Load filter state and stage-one item on accept
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fast   <= '0;
            r_slow   <= '0;
            r_s1_vld <= 1'b0;
        end else begin
            if (in_acc && r_en) begin
                r_fast <= n_fast;
                r_slow <= n_slow;
            end
            if (in_acc) begin
                r_s1_vld <= 1'b1;
            end else if (s1_adv) begin
                r_s1_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_raw <= i_in.sample;
        end
    end

    // Form the used sample: integer part of the difference, saturated, or the raw sample while filtering is off
    always_comb begin
        d_avg     = {r_fast[AW-1], r_fast} - {r_slow[AW-1], r_slow};
        filt_wide = d_avg[DW-1:zchs_pkg::FRAC_BITS];
        if (filt_wide[SAMPLE_BITS] != filt_wide[SAMPLE_BITS-1]) begin
            filt_sat = filt_wide[SAMPLE_BITS] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                                              : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end else begin
            filt_sat = filt_wide[SAMPLE_BITS-1:0];
        end
        used = r_en ? filt_sat : r_raw;
    end

    // Crossing detection and sample point match
    always_comb begin
        neg      = used[SAMPLE_BITS-1];
        pos      = !neg && (used != '0);
        crossing = neg != r_prev_neg;
        hit_e    = r_cnt == r_early;
        hit_l    = r_cnt == r_late;
        emit     = !crossing && (hit_e || hit_l);
        if (crossing) begin
            n_cnt = zchs_pkg::t_cnt'(1);
        end else if (r_cnt == zchs_pkg::CNT_MAX) begin
            n_cnt = r_cnt;
        end else begin
            n_cnt = r_cnt + zchs_pkg::t_cnt'(1);
        end
    end

    // Advance crossing state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_neg <= 1'b0;
            r_cnt      <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            if (s1_adv) begin
                r_prev_neg <= neg;
                r_cnt      <= n_cnt;
            end
            if (s1_adv && emit) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && emit) begin
            r_out_bit <= pos;
            r_out_pt  <= hit_e ? zchs_pkg::POINT_EARLY : zchs_pkg::POINT_LATE;
        end
    end

    assign o_out.valid        = r_out_vld;
    assign o_out.polarity     = r_out_bit;
    assign o_out.sample_point = r_out_pt;

    // A produced result shows up in the output register with its value
    a_emit_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv && emit |=> o_out.valid && (o_out.polarity == $past(pos)))
        else $error("result not loaded into output register");

    // No new sample while stage one holds a stalled item
    a_no_accept_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld && !s1_adv |-> !i_in.ready)
        else $error("input accepted while stage one stalled");

    // Counter saturates instead of wrapping
    a_cnt_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == zchs_pkg::CNT_MAX) && s1_adv && !crossing |=> r_cnt == zchs_pkg::CNT_MAX)
        else $error("crossing counter wrapped");

    // Filters hold while filtering is off
    a_filter_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && !r_en |=> $stable(r_fast) && $stable(r_slow))
        else $error("filter state moved with filtering disabled");

endmodule

>>> dv/zchs_halfbit_check.sv
// Checker for the zero-crossing half-bit sampler: watches the config port and both channels.
// Predicts half-bit items per accepted sample and compares them in order.
// Depends on zchs_pkg, zchs_in_if and zchs_out_if.
`timescale 1ns / 100ps

module zchs_halfbit_check #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [zchs_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  logic [zchs_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    zchs_in_if                                   i_in,
    zchs_out_if                                  i_out,
    output int                                   o_fail_count,
    output int                                   o_pending,
    output int                                   o_samples,
    output int                                   o_results
);

    localparam longint SAMPLE_MAX = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
    localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;
    localparam int     MAX_REPORTS = 10;

    typedef struct packed {
        logic polarity;
        logic sample_point;
    } t_halfbit;

    // Local copy of the registers
    logic             filt_en;
    zchs_pkg::t_shift fast_shift;
    zchs_pkg::t_shift slow_shift;
    zchs_pkg::t_cnt   early_pt;
    zchs_pkg::t_cnt   late_pt;

    // Local copy of the filter and crossing state
    longint         fast_avg;
    longint         slow_avg;
    logic           prev_neg;
    zchs_pkg::t_cnt since_cross;

    t_halfbit halfbit_q[$];

    // Advance the filters and crossing counter by one sample; queue a half-bit if one is due
    function automatic void predict_halfbit(input logic signed [SAMPLE_BITS-1:0] smp);
        longint   level;
        longint   x_q16;
        logic     neg;
        t_halfbit hb;
        level = longint'(smp);
        if (filt_en) begin
            x_q16    = level <<< zchs_pkg::FRAC_BITS;
            fast_avg = fast_avg + ((x_q16 - fast_avg) >>> fast_shift);
            slow_avg = slow_avg + ((x_q16 - slow_avg) >>> slow_shift);
            level    = (fast_avg - slow_avg) >>> zchs_pkg::FRAC_BITS;
            if (level > SAMPLE_MAX) level = SAMPLE_MAX;
            if (level < SAMPLE_MIN) level = SAMPLE_MIN;
        end
        neg = (level < 0);
        if (neg != prev_neg) begin
            since_cross = '0;
        end else if (since_cross == early_pt || since_cross == late_pt) begin
            hb.polarity     = (level > 0);
            hb.sample_point = (since_cross == early_pt) ? zchs_pkg::POINT_EARLY
                                                        : zchs_pkg::POINT_LATE;
            halfbit_q.push_back(hb);
        end
        prev_neg = neg;
        if (since_cross != zchs_pkg::CNT_MAX) since_cross = since_cross + 1'b1;
    endfunction

    always @(posedge i_clk) begin
        t_halfbit want;
        t_halfbit got;
        if (!i_rst_n) begin
            filt_en     = zchs_pkg::RST_ENABLE_FILTER;
            fast_shift  = zchs_pkg::RST_SIGNAL_SHIFT;
            slow_shift  = zchs_pkg::RST_DC_SHIFT;
            early_pt    = zchs_pkg::RST_EARLY_OFFSET;
            late_pt     = zchs_pkg::RST_LATE_OFFSET;
            fast_avg    = 0;
            slow_avg    = 0;
            prev_neg    = 1'b0;
            since_cross = '0;
            halfbit_q.delete();
        end else begin
            // Track register writes
            if (i_cfg_we) begin
                case (zchs_pkg::t_cfg_reg'(i_cfg_idx))
                    zchs_pkg::CFG_ENABLE_FILTER: filt_en    = i_cfg_data[0];
                    zchs_pkg::CFG_SIGNAL_SHIFT:  fast_shift = i_cfg_data;
                    zchs_pkg::CFG_DC_SHIFT:      slow_shift = i_cfg_data;
                    zchs_pkg::CFG_EARLY_OFFSET:  early_pt   = i_cfg_data;
                    zchs_pkg::CFG_LATE_OFFSET:   late_pt    = i_cfg_data;
                    default: ;
                endcase
            end

            // Compare an accepted result with the oldest expected half-bit
            if (i_out.valid && i_out.ready) begin
                o_results        = o_results + 1;
                got.polarity     = i_out.polarity;
                got.sample_point = i_out.sample_point;
                if (halfbit_q.size() == 0) begin
                    o_fail_count = o_fail_count + 1;
                    if (o_fail_count <= MAX_REPORTS)
                        $display("%0t: unexpected half-bit item: polarity=%b sample_point=%b",
                                 $realtime, got.polarity, got.sample_point);
                end else begin
                    want = halfbit_q.pop_front();
                    if (got.polarity !== want.polarity ||
                        got.sample_point !== want.sample_point) begin
                        o_fail_count = o_fail_count + 1;
                        if (o_fail_count <= MAX_REPORTS)
                            $display("%0t: mismatch on result %0d: polarity exp %b got %b, %s",
                                     $realtime, o_results, want.polarity, got.polarity,
                                     $sformatf("sample_point exp %b got %b",
                                               want.sample_point, got.sample_point));
                    end
                end
            end

            // Predict from an accepted sample
            if (i_in.valid && i_in.ready) begin
                o_samples = o_samples + 1;
                predict_halfbit(i_in.sample);
            end
        end
        o_pending = halfbit_q.size();
    end

endmodule

>>> dv/zero_crossing_halfbit_sampler_unit_tb.sv
// Testbench top for the zero-crossing half-bit sampler: clock, reset, register
// settings, sample stimulus and output backpressure; verdict from zchs_halfbit_check.
// Depends on zchs_pkg, zchs_in_if, zchs_out_if, the sampler RTL and the checker.
`timescale 1ns / 100ps

module zero_crossing_halfbit_sampler_unit_tb;

    localparam int SAMPLE_BITS    = 16;
    localparam int SAMPLE_MAX     = (1 <<< (SAMPLE_BITS - 1)) - 1;
    localparam int SAMPLE_MIN     = -SAMPLE_MAX - 1;
    localparam int PHASE_ITEMS    = 288;
    localparam int NUM_PHASES     = 6;
    localparam int DRAIN_CYCLES   = 8;
    localparam int HOLD_CYCLES    = 300;
    localparam int PRESSURE_PHASE = 6;
    localparam int STALL_LIMIT    = 4000;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n;
    logic                               cfg_we;
    logic [zchs_pkg::CFG_IDX_BITS-1:0]  cfg_idx;
    logic [zchs_pkg::CFG_DATA_BITS-1:0] cfg_data;

    zchs_in_if #(.SAMPLE_BITS(SAMPLE_BITS)) in_ch();
    zchs_out_if                             out_ch();

    int fail_count;
    int pending;
    int samples_seen;
    int results_seen;

    int tx_idle_pct;
    int rx_idle_pct;
    int phase_id;
    int hold_left    = 0;
    bit hold_done    = 1'b0;
    int quiet_cycles = 0;

    int dir_samples[$] = '{0, 32767, 32767, 32767, 32767, -32768, -32768, -32768, -32768,
                           0, 0, 0, 1, -1, 1, 32767, 32767, 32767, -32768, -32768,
                           -32768, 21845, -21846, 0};

    zero_crossing_halfbit_sampler_unit #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    zchs_halfbit_check #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_samples    (samples_seen),
        .o_results    (results_seen)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Output backpressure: random stalls, plus one long hold while samples keep coming
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            out_ch.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end else if (!hold_done && phase_id == PRESSURE_PHASE && out_ch.valid) begin
            out_ch.ready <= 1'b0;
            hold_left    <= HOLD_CYCLES;
            hold_done    <= 1'b1;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // End the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || cfg_we || (in_ch.valid && in_ch.ready) ||
            (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Timeout: no item moved for %0d cycles, %0d results outstanding",
                     quiet_cycles, pending);
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one sample after a random gap and hold it until taken
    task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] smp);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid  <= 1'b1;
        in_ch.sample <= smp;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input zchs_pkg::t_cfg_reg cfg_reg,
                             input logic [zchs_pkg::CFG_DATA_BITS-1:0] value);
        cfg_we   <= 1'b1;
        cfg_idx  <= cfg_reg;
        cfg_data <= value;
        @(negedge i_clk);
    endtask

    task automatic apply_settings(input logic en, input zchs_pkg::t_shift sig_sh,
                                  input zchs_pkg::t_shift dc_sh,
                                  input zchs_pkg::t_cnt early, input zchs_pkg::t_cnt late);
        write_reg(zchs_pkg::CFG_ENABLE_FILTER, {3'b000, en});
        write_reg(zchs_pkg::CFG_SIGNAL_SHIFT, sig_sh);
        write_reg(zchs_pkg::CFG_DC_SHIFT, dc_sh);
        write_reg(zchs_pkg::CFG_EARLY_OFFSET, early);
        write_reg(zchs_pkg::CFG_LATE_OFFSET, late);
        cfg_we <= 1'b0;
    endtask

    // Drop valid, wait out every expected result, then let the pipeline empty
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Mostly square-wave bursts with noise and random polarity lengths, some full-range noise
    task automatic run_random(input int n_items, input int long_pct);
        int left;
        int amp;
        int noise;
        int half_len;
        int v;
        bit pol;
        left = n_items;
        pol  = 1'($urandom_range(1));
        while (left > 0) begin
            if ($urandom_range(99) < 12) begin
                repeat ($urandom_range(1, 6)) begin
                    if (left > 0) begin
                        send_sample(SAMPLE_BITS'($urandom));
                        left--;
                    end
                end
            end else begin
                amp   = ($urandom_range(7) == 0) ? SAMPLE_MAX
                                                 : int'($urandom_range(1, SAMPLE_MAX));
                noise = int'($urandom_range(0, amp / 4));
                repeat ($urandom_range(1, 8)) begin
                    half_len = ($urandom_range(99) < long_pct) ? int'($urandom_range(60, 250))
                                                               : int'($urandom_range(1, 18));
                    pol = !pol;
                    repeat (half_len) begin
                        if (left > 0) begin
                            v = (pol ? amp : -amp - 1) + int'($urandom_range(0, 2 * noise))
                                - noise;
                            if (v > SAMPLE_MAX) v = SAMPLE_MAX;
                            if (v < SAMPLE_MIN) v = SAMPLE_MIN;
                            send_sample(SAMPLE_BITS'(v));
                            left--;
                        end
                    end
                end
            end
        end
    endtask

    initial begin
        int ph;
        i_rst_n      = 1'b0;
        cfg_we       = 1'b0;
        cfg_idx      = '0;
        cfg_data     = '0;
        in_ch.valid  = 1'b0;
        in_ch.sample = '0;
        tx_idle_pct  = 28;
        rx_idle_pct  = 79;
        phase_id     = 0;

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: offset zero hits the counter left by reset; extremes and small steps
        write_reg(zchs_pkg::CFG_EARLY_OFFSET, 4'd0);
        cfg_we <= 1'b0;
        foreach (dir_samples[k]) send_sample(SAMPLE_BITS'(dir_samples[k]));
        settle();

        // Random phases over several register settings
        for (ph = 1; ph <= NUM_PHASES; ph++) begin
            phase_id = ph;
            if (ph >= 5) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end else if (ph >= 3) begin
                tx_idle_pct = 79;
                rx_idle_pct = 28;
            end
            case (ph)
                1: apply_settings(1'b1, 4'd0, 4'd4, 4'd1, 4'd14);
                2: apply_settings(1'b0, 4'd3, 4'd5, 4'd15, 4'd15);
                3: apply_settings(1'b1, 4'd15, 4'd15, 4'd14, 4'd1);
                4: apply_settings(1'b1, zchs_pkg::RST_SIGNAL_SHIFT, zchs_pkg::RST_DC_SHIFT,
                                  zchs_pkg::RST_EARLY_OFFSET, zchs_pkg::RST_LATE_OFFSET);
                5: apply_settings(1'b0, zchs_pkg::t_shift'($urandom),
                                  zchs_pkg::t_shift'($urandom),
                                  zchs_pkg::t_cnt'($urandom_range(1, 14)),
                                  zchs_pkg::t_cnt'($urandom_range(1, 14)));
                default: apply_settings(1'b1, 4'd4, 4'd0, 4'd6, 4'd6);
            endcase
            run_random(PHASE_ITEMS, (ph == 1 || ph == 3) ? 35 : 8);
            settle();
        end

        $display("Run covered %0d samples over %0d register settings, %0d half-bit results checked",
                 samples_seen, NUM_PHASES + 1, results_seen);
        $display("incl. raw and filtered paths, shifts 0 and 15, offsets 0, 1, 14, 15 and equal,");
        $display("and a %0d-cycle output hold under a full input stream", HOLD_CYCLES);
        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("Failures: %0d, results still expected: %0d", fail_count, pending);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
